### design/assert_macros.svh
// Assertion macros used by fit_block_allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/fba_pkg.sv
package fba_pkg;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ZERO_SIZE   = 3'd1;
  localparam logic [2:0] ST_NO_MEMORY   = 3'd2;
  localparam logic [2:0] ST_FRAGMENTED  = 3'd3;
  localparam logic [2:0] ST_INVALID_IDX = 3'd4;
  localparam logic [2:0] ST_DOUBLE_FREE = 3'd5;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [14:0] BYTE_OUT_MAX = 15'h7FFF;

  typedef struct packed {
    logic        req_type;
    logic [15:0] size_bytes;
    logic [15:0] start_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  seg_start;
    logic [8:0]  seg_blocks;
    logic [31:0] grant_id;
    logic [14:0] bytes_in_use;
    logic [14:0] peak_bytes;
  } resp_t;

endpackage

### design/fit_block_allocator.sv
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid/req_stall   | fba_pkg::req_t
// resp    | out       | resp_valid/resp_stall | fba_pkg::resp_t
// cfg     | in        | cfg_we                | cfg_data (fit_mode)
//
// An allocate walks the segment chain twice, reading each segment's address, then its data.
// After reset a clearing pass runs before items are taken.
// A finished item waits in the output register while resp_stall is high, and the next
// item is taken in the cycle after the result leaves.
`include "assert_macros.svh"

module fit_block_allocator #(
  parameter int NUM_BLOCKS      = 256,
  parameter int BYTES_PER_BLOCK = 64,
  parameter int HEADER_BYTES    = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_data,
  input  logic           req_valid,
  output logic           req_stall,
  input  fba_pkg::req_t  req,
  output logic           resp_valid,
  input  logic           resp_stall,
  output fba_pkg::resp_t resp
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int LW = IW + 1;
  localparam int BW = $clog2(NUM_BLOCKS * BYTES_PER_BLOCK + 1) + 1;
  localparam int NW = 18;
  localparam int PW = NW + 32;
  localparam int RSH = 31;
  localparam logic [31:0] RECIP = 32'(((64'd1 << RSH) + 64'(BYTES_PER_BLOCK) - 64'd1)
                                      / 64'(BYTES_PER_BLOCK));

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SUM_RD, S_SUM, S_FIT_RD, S_FIT, S_SPLIT,
    S_FREE_RD, S_FREE_CHK, S_NEXT_RD, S_MERGE, S_OUT
  } state_t;

  // Entry: head, free, length.
  typedef struct packed {
    logic          head;
    logic          free;
    logic [LW-1:0] len;
  } ent_t;

  ent_t mem [NUM_BLOCKS];
  ent_t rd;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  ent_t          wr_data;

  state_t        state;
  logic          fit_mode;
  logic [LW-1:0] idx;
  logic [LW-1:0] need;
  logic [LW-1:0] total;
  logic          found;
  logic [IW-1:0] pick;
  logic [LW-1:0] pick_len;
  logic [IW-1:0] fstart;
  logic [LW-1:0] flen;
  logic [31:0]   id_counter;
  logic [BW-1:0] used;
  logic [BW-1:0] peak;
  logic [15:0]   fidx;
  fba_pkg::resp_t resp_r;

  // The split remainder and a merged-away entry are written through the shared port
  // during the first cycle of S_OUT.
  logic          rest_pend;
  logic [IW-1:0] rest_addr;
  logic [LW-1:0] rest_len;
  logic          kill_pend;
  logic          merge;

  logic [NW-1:0] need_sum;
  logic [PW-1:0] need_prod;
  logic [NW-1:0] need_full;
  logic [LW-1:0] nxt_free;
  logic [BW-1:0] delta;

  // The block count is a constant reciprocal multiplication, exact over the whole input range.
  assign need_sum  = NW'(req.size_bytes) + NW'(HEADER_BYTES + BYTES_PER_BLOCK - 1);
  assign need_prod = PW'(need_sum) * PW'(RECIP);
  assign need_full = need_prod[RSH +: NW];
  assign nxt_free  = LW'(fstart) + flen;
  assign delta     = BW'(need) * BW'(BYTES_PER_BLOCK);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd <= mem[rd_addr];
  end

  function automatic logic [14:0] sat(input logic [BW-1:0] v);
    if (v > BW'(fba_pkg::BYTE_OUT_MAX)) begin
      return fba_pkg::BYTE_OUT_MAX;
    end
    return 15'(v);
  endfunction

  function automatic fba_pkg::resp_t mk_resp(input logic [2:0] st, input logic [7:0] start,
                                             input logic [8:0] blocks, input logic [31:0] id);
    return '{status: st, seg_start: start, seg_blocks: blocks, grant_id: id,
             bytes_in_use: 15'd0, peak_bytes: 15'd0};
  endfunction

  always_comb begin
    rd_addr = idx[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx[IW-1:0];
    wr_data = '0;
    merge   = (nxt_free < LW'(NUM_BLOCKS)) && rd.head && rd.free;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (idx == '0) begin
          wr_data = '{head: 1'b1, free: 1'b1, len: LW'(NUM_BLOCKS)};
        end
      end
      S_FREE_RD: rd_addr = fidx[IW-1:0];
      S_SPLIT: begin
        wr_en   = found;
        wr_addr = pick;
        wr_data = '{head: 1'b1, free: 1'b0, len: need};
      end
      S_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = fstart;
        wr_data = '{head: 1'b1, free: 1'b1, len: merge ? flen + rd.len : flen};
      end
      S_OUT: begin
        wr_en   = rest_pend || kill_pend;
        wr_addr = rest_addr;
        if (rest_pend) begin
          wr_data = '{head: 1'b1, free: 1'b1, len: rest_len};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      fit_mode   <= 1'b0;
      id_counter <= '0;
      used       <= '0;
      peak       <= '0;
      resp_valid <= 1'b0;
      rest_pend  <= 1'b0;
      kill_pend  <= 1'b0;
    end else begin
      if (cfg_we) begin
        fit_mode <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          if (idx == LW'(NUM_BLOCKS - 1)) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + LW'(1);
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            idx   <= '0;
            total <= '0;
            found <= 1'b0;
            fidx  <= req.start_index;
            if (req.req_type == fba_pkg::REQ_FREE) begin
              state <= S_FREE_RD;
            end else if (req.size_bytes == '0) begin
              resp_r <= mk_resp(fba_pkg::ST_ZERO_SIZE, 8'd0, 9'd0, 32'd0);
              state  <= S_OUT;
            end else if (need_full > NW'(NUM_BLOCKS)) begin
              resp_r <= mk_resp(fba_pkg::ST_NO_MEMORY, 8'd0, 9'd0, 32'd0);
              state  <= S_OUT;
            end else begin
              need  <= LW'(need_full);
              state <= S_SUM_RD;
            end
          end
        end
        S_SUM_RD: state <= S_SUM;
        S_SUM: begin
          if (rd.free) begin
            total <= total + rd.len;
          end
          if (idx + rd.len >= LW'(NUM_BLOCKS) || rd.len == '0) begin
            idx   <= '0;
            state <= S_FIT_RD;
          end else begin
            idx   <= idx + rd.len;
            state <= S_SUM_RD;
          end
        end
        S_FIT_RD: begin
          if (total < need) begin
            resp_r <= mk_resp(fba_pkg::ST_NO_MEMORY, 8'd0, 9'd0, 32'd0);
            state  <= S_OUT;
          end else begin
            state <= S_FIT;
          end
        end
        S_FIT: begin
          if (rd.free && rd.len >= need && (!found || rd.len < pick_len)) begin
            found    <= 1'b1;
            pick     <= idx[IW-1:0];
            pick_len <= rd.len;
          end
          if ((rd.free && rd.len >= need && !found && !fit_mode)
              || idx + rd.len >= LW'(NUM_BLOCKS) || rd.len == '0) begin
            state <= S_SPLIT;
          end else begin
            idx   <= idx + rd.len;
            state <= S_FIT_RD;
          end
        end
        S_SPLIT: begin
          if (!found) begin
            resp_r <= mk_resp(fba_pkg::ST_FRAGMENTED, 8'd0, 9'd0, 32'd0);
            state  <= S_OUT;
          end else begin
            rest_pend  <= pick_len > need;
            rest_addr  <= IW'(LW'(pick) + need);
            rest_len   <= pick_len - need;
            id_counter <= id_counter + 32'd1;
            used       <= used + delta;
            if (used + delta > peak) begin
              peak <= used + delta;
            end
            resp_r <= mk_resp(fba_pkg::ST_OK, 8'(pick), 9'(need), id_counter + 32'd1);
            state  <= S_OUT;
          end
        end
        S_FREE_RD: begin
          state <= S_FREE_CHK;
        end
        S_FREE_CHK: begin
          if (fidx >= 16'(NUM_BLOCKS) || !rd.head) begin
            resp_r <= mk_resp(fba_pkg::ST_INVALID_IDX, 8'd0, 9'd0, 32'd0);
            state  <= S_OUT;
          end else if (rd.free) begin
            resp_r <= mk_resp(fba_pkg::ST_DOUBLE_FREE, 8'd0, 9'd0, 32'd0);
            state  <= S_OUT;
          end else begin
            fstart <= fidx[IW-1:0];
            flen   <= rd.len;
            used   <= used - BW'(rd.len) * BW'(BYTES_PER_BLOCK);
            idx    <= LW'(fidx[IW-1:0]) + rd.len;
            state  <= S_NEXT_RD;
          end
        end
        S_NEXT_RD: begin
          state <= S_MERGE;
        end
        S_MERGE: begin
          kill_pend <= merge;
          rest_addr <= nxt_free[IW-1:0];
          resp_r    <= mk_resp(fba_pkg::ST_OK, 8'(fstart), 9'(flen), 32'd0);
          state     <= S_OUT;
        end
        S_OUT: begin
          if (rest_pend || kill_pend) begin
            rest_pend <= 1'b0;
            kill_pend <= 1'b0;
          end else if (!resp_valid) begin
            resp_valid <= 1'b1;
            resp       <= '{status: resp_r.status, seg_start: resp_r.seg_start,
                            seg_blocks: resp_r.seg_blocks, grant_id: resp_r.grant_id,
                            bytes_in_use: sat(used), peak_bytes: sat(peak)};
          end else if (!resp_stall) begin
            resp_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_stall = (state != S_IDLE);

`ASSERT_IMPL(a_out_idle, clk, rst, resp_valid, state == S_OUT, "result outside output state")
`ASSERT_IMPL(a_grant_ok, clk, rst, resp_valid && resp.grant_id != '0, resp.status == fba_pkg::ST_OK, "id on failure")
`ASSERT_IMPL(a_peak, clk, rst, 1'b1, peak >= used, "peak below usage")
`ASSERT_NEXT(a_hold, clk, rst, resp_valid && resp_stall, resp_valid && $stable(resp), "result dropped")

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int NBLK = 256;
  localparam int BPB = 64;
  localparam int HDR = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1170;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_data;
  logic req_valid;
  logic req_stall;
  fba_pkg::req_t req;
  logic resp_valid;
  logic resp_stall;
  fba_pkg::resp_t resp;

  fit_block_allocator uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .resp_valid(resp_valid), .resp_stall(resp_stall), .resp(resp)
  );

  // Shadow copy of the segment chain.
  bit pool_head[NBLK];
  bit pool_free[NBLK];
  int pool_len[NBLK];
  bit [31:0] next_id;
  longint used_total;
  longint peak_total;
  bit mode_best;

  fba_pkg::resp_t pending_resp[$];
  int live_starts[$];
  int errors;
  int idle_cycles;
  bit hold_off;

  typedef struct {
    bit kind;
    int size;
    int start;
    bit has_exp;
    logic [2:0] exp_status;
  } row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [14:0] sat15(longint v);
    return (v > 32767) ? 15'h7FFF : v[14:0];
  endfunction

  function automatic fba_pkg::resp_t make_resp(logic [2:0] st, int s, int n, bit [31:0] id);
    fba_pkg::resp_t r;
    r.status = st;
    r.seg_start = s[7:0];
    r.seg_blocks = n[8:0];
    r.grant_id = id;
    r.bytes_in_use = sat15(used_total);
    r.peak_bytes = sat15(peak_total);
    return r;
  endfunction

  function automatic fba_pkg::resp_t allocate_blocks(int size);
    int need;
    int total;
    int i;
    int pick;
    int pick_len;
    bit found;
    total = 0;
    pick = 0;
    pick_len = 0;
    found = 0;
    if (size == 0) return make_resp(fba_pkg::ST_ZERO_SIZE, 0, 0, 0);
    need = (size + HDR + BPB - 1) / BPB;
    for (i = 0; i < NBLK && pool_len[i] != 0; i += pool_len[i])
      if (pool_free[i]) total += pool_len[i];
    if (need > total) return make_resp(fba_pkg::ST_NO_MEMORY, 0, 0, 0);
    for (i = 0; i < NBLK && pool_len[i] != 0; i += pool_len[i]) begin
      if (!pool_free[i] || pool_len[i] < need) continue;
      if (!found || pool_len[i] < pick_len) begin
        found = 1;
        pick = i;
        pick_len = pool_len[i];
        if (!mode_best) break;
      end
    end
    if (!found) return make_resp(fba_pkg::ST_FRAGMENTED, 0, 0, 0);
    if (pick_len > need) begin
      pool_head[pick + need] = 1;
      pool_free[pick + need] = 1;
      pool_len[pick + need] = pick_len - need;
      pool_len[pick] = need;
    end
    next_id++;
    pool_free[pick] = 0;
    used_total += need * BPB;
    if (used_total > peak_total) peak_total = used_total;
    live_starts.push_back(pick);
    return make_resp(fba_pkg::ST_OK, pick, need, next_id);
  endfunction

  function automatic fba_pkg::resp_t free_segment(int start);
    int len;
    int nxt;
    if (start >= NBLK || !pool_head[start]) return make_resp(fba_pkg::ST_INVALID_IDX, 0, 0, 0);
    if (pool_free[start]) return make_resp(fba_pkg::ST_DOUBLE_FREE, 0, 0, 0);
    len = pool_len[start];
    used_total -= len * BPB;
    pool_free[start] = 1;
    nxt = start + len;
    if (nxt < NBLK && pool_head[nxt] && pool_free[nxt]) begin
      pool_len[start] = len + pool_len[nxt];
      pool_head[nxt] = 0;
      pool_free[nxt] = 0;
      pool_len[nxt] = 0;
    end
    foreach (live_starts[k])
      if (live_starts[k] == start) begin
        live_starts.delete(k);
        break;
      end
    return make_resp(fba_pkg::ST_OK, start, len, 0);
  endfunction

  // Sends one item and records its expected result once it is accepted.
  task automatic send_item(bit kind, int size, int start, bit has_exp, logic [2:0] st);
    fba_pkg::resp_t r;
    req_valid <= 1'b1;
    req <= '{req_type: kind, size_bytes: size[15:0], start_index: start[15:0]};
    do @(posedge clk); while (req_stall);
    r = kind ? free_segment(start) : allocate_blocks(size);
    if (has_exp && r.status !== st) begin
      $display("%0t directed status expected %0d actual %0d", $time, st, r.status);
      errors++;
    end
    pending_resp.push_back(r);
  endtask

  task automatic pause_sender(int n);
    req_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_best = m;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) send_item(fba_pkg::REQ_ALLOC, $urandom_range(1, 2000), 0, 0, 0);
    else if (r < 53) send_item(fba_pkg::REQ_ALLOC, $urandom_range(0, 65535), 0, 0, 0);
    else if (r < 85 && live_starts.size() != 0)
      send_item(fba_pkg::REQ_FREE, $urandom(),
                live_starts[$urandom_range(0, live_starts.size() - 1)], 0, 0);
    else if (r < 95) send_item(fba_pkg::REQ_FREE, $urandom(), $urandom_range(0, 255), 0, 0);
    else send_item(fba_pkg::REQ_FREE, $urandom(), $urandom_range(0, 65535), 0, 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      resp_stall <= 1'b0;
    end else begin
      resp_stall <= hold_off || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && resp_valid && !resp_stall) begin
      if (pending_resp.size() == 0) begin
        $display("%0t unexpected result actual %h", $time, resp);
        errors++;
      end else begin
        fba_pkg::resp_t e;
        e = pending_resp.pop_front();
        if (resp !== e) begin
          $display("%0t mismatch expected %h actual %h", $time, e, resp);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (resp_valid && !resp_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    int n;
    int burst;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    req_valid = 1'b0;
    req = '0;
    hold_off = 1'b0;
    errors = 0;
    idle_cycles = 0;
    foreach (pool_len[i]) begin
      pool_head[i] = 0;
      pool_free[i] = 0;
      pool_len[i] = 0;
    end
    pool_head[0] = 1;
    pool_free[0] = 1;
    pool_len[0] = NBLK;
    next_id = 0;
    used_total = 0;
    peak_total = 0;
    mode_best = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mode(1'b0);

    rows = '{
      '{fba_pkg::REQ_ALLOC, 0, 0, 1, fba_pkg::ST_ZERO_SIZE},
      '{fba_pkg::REQ_ALLOC, 65535, 0, 1, fba_pkg::ST_NO_MEMORY},
      '{fba_pkg::REQ_FREE, 0, 0, 1, fba_pkg::ST_DOUBLE_FREE},
      '{fba_pkg::REQ_FREE, 0, 65535, 1, fba_pkg::ST_INVALID_IDX},
      '{fba_pkg::REQ_FREE, 0, 256, 1, fba_pkg::ST_INVALID_IDX},
      '{fba_pkg::REQ_ALLOC, 1, 0, 1, fba_pkg::ST_OK},
      '{fba_pkg::REQ_ALLOC, 500, 0, 0, 0},
      '{fba_pkg::REQ_ALLOC, 100, 0, 0, 0},
      '{fba_pkg::REQ_ALLOC, 1000, 0, 0, 0},
      '{fba_pkg::REQ_FREE, 0, 1, 0, 0},
      '{fba_pkg::REQ_FREE, 0, 1, 1, fba_pkg::ST_DOUBLE_FREE},
      '{fba_pkg::REQ_FREE, 0, 2, 1, fba_pkg::ST_INVALID_IDX},
      '{fba_pkg::REQ_FREE, 0, 0, 0, 0},
      '{fba_pkg::REQ_ALLOC, 32, 0, 0, 0},
      '{fba_pkg::REQ_ALLOC, 14000, 0, 0, 0},
      '{fba_pkg::REQ_ALLOC, 3000, 0, 1, fba_pkg::ST_NO_MEMORY},
      '{fba_pkg::REQ_FREE, 65535, 255, 0, 0}
    };
    foreach (rows[i])
      send_item(rows[i].kind, rows[i].size, rows[i].start, rows[i].has_exp,
                rows[i].exp_status);
    drain();

    // Fragment the pool so that a large request fails with enough free blocks.
    // The sixteen-block grants land at block 13 and then at 30, 46, ... 238.
    write_mode(1'b1);
    while (live_starts.size() != 0) send_item(fba_pkg::REQ_FREE, 0, live_starts[0], 0, 0);
    for (int i = 0; i < 16; i++) send_item(fba_pkg::REQ_ALLOC, 992, 0, 0, 0);
    for (int i = 0; i < 7; i++) send_item(fba_pkg::REQ_FREE, 0, 30 + i * 32, 0, 0);
    send_item(fba_pkg::REQ_ALLOC, 2000, 0, 1, fba_pkg::ST_FRAGMENTED);
    send_item(fba_pkg::REQ_ALLOC, 100, 0, 0, 0);
    drain();

    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && n < RANDOM_ITEMS; k++) begin
        if (n == 300) begin
          drain();
          write_mode(1'b0);
        end else if (n == 700) begin
          drain();
          write_mode(1'b1);
        end else if (n == 500) begin
          hold_off = 1'b1;
          fork
            begin
              repeat (3000) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        random_item();
        n++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
    end
    drain();

    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

### fit_block_allocator.f
+incdir+design
design/fba_pkg.sv
design/fit_block_allocator.sv
bench/tb_top.sv
